>>> rtl/core/csrast_pkg.sv
// ----------------------------------------------------------------------------
// Circle span rasteriser package
// Shared widths, codes, state type and payload structs of the rasteriser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csrast_pkg;

    localparam int COORD_W   = 16;
    localparam int RAD_W     = 14;
    localparam int COLOR_W   = 24;
    localparam int PIX_W     = 32;
    localparam int OUT_W     = 12;
    localparam int REG_W     = 13;
    localparam int ROW_W     = REG_W;
    localparam int REM_W     = 2 * RAD_W;
    localparam int STEP_W    = $clog2(RAD_W);
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hff000000;

    localparam logic [REG_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [REG_W-1:0] RST_SCREEN_HEIGHT = 13'd768;
    localparam logic             RST_FILL_MODE     = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_ROOT,
        ST_EMIT
    } csrast_state_t;

    typedef struct packed {
        logic                      opcode;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [RAD_W-1:0]          circle_radius;
        logic [COLOR_W-1:0]        fill_color;
    } csrast_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] span_start;
        logic [OUT_W-1:0] span_end;
        logic [PIX_W-1:0] pixel_color;
        logic             whole_span;
        logic             last_span;
    } csrast_out_t;

endpackage

>>> rtl/core/csrast_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add product of a radius-sized operand and a one-bit-wider one, one multiplier bit per
// cycle, used to form the squared remainder of the first row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csrast_mul
    import csrast_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [RAD_W-1:0] mul_a,
    input  logic [RAD_W:0]   mul_b,
    output logic             done,
    output logic [REM_W-1:0] product
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W:0]    hi_reg, hi_next;
    logic [RAD_W-1:0]  lo_reg, lo_next;
    logic [RAD_W:0]    b_reg, b_next;
    logic [RAD_W+1:0]  sum;

    always_comb begin
        sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, b_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            hi_next   = '0;
            lo_next   = mul_a;
            b_next    = mul_b;
        end else if (busy_reg) begin
            hi_next  = sum[RAD_W+1:1];
            lo_next  = {sum[0], lo_reg[RAD_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(RAD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        b_reg  <= b_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg[RAD_W-1:0], lo_reg};

endmodule

>>> rtl/core/csrast_isqrt.sv
// ----------------------------------------------------------------------------
// Digit-serial integer square root
// Restoring square root that consumes two radicand bits and produces one
// root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csrast_isqrt
    import csrast_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [REM_W-1:0] operand,
    output logic             done,
    output logic [RAD_W-1:0] root
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]  src_reg, src_next;
    logic [RAD_W+1:0]  part_reg, part_next;
    logic [RAD_W-1:0]  root_reg, root_next;
    logic [RAD_W+3:0]  work;
    logic [RAD_W+3:0]  trial;
    logic [RAD_W+3:0]  diff;
    logic              fits;

    always_comb begin
        work  = {part_reg, src_reg[REM_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        diff  = work - trial;
        fits  = (work >= trial);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        part_next = part_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            src_next  = operand;
            part_next = '0;
            root_next = '0;
        end else if (busy_reg) begin
            src_next  = {src_reg[REM_W-3:0], 2'b00};
            part_next = fits ? diff[RAD_W+1:0] : work[RAD_W+1:0];
            root_next = {root_reg[RAD_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(RAD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        src_reg  <= src_next;
        part_reg <= part_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/core/circle_span_rasterizer_top.sv
// A start transfer holds the block in the prepare and multiply states (prepare only
// when off screen) while the bit-serial multiplier forms the first squared remainder.
// A next-row transfer runs the 14-step digit-serial square root in the root state, then
// waits in the emit state for a free output; new transfers are taken only in idle.
// Reset is synchronous and active low; it restores the register defaults and drops
// any circle in progress. There is no clearing pass.
// ----------------------------------------------------------------------------
// Circle span rasteriser
// Produces one clamped scanline span per next-row request for the active circle,
// updating the squared remainder incrementally from row to row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_span_rasterizer_top
    import csrast_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  csrast_in_t           s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output csrast_out_t          m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]     cfg_wdata
);

    localparam int SPAN_W = COORD_W + 2;
    localparam int EDGE_W = COORD_W + 1;

    function automatic logic [REG_W-1:0] eff_limit(input logic [REG_W-1:0] value,
                                                   input int maxv);
        logic [REG_W-1:0] res;
        if (value == '0) begin
            res = REG_W'(1);
        end else if (32'(value) > maxv) begin
            res = REG_W'(maxv);
        end else begin
            res = value;
        end
        return res;
    endfunction

    function automatic logic [REG_W-1:0] clamp_col(input logic signed [SPAN_W-1:0] v,
                                                   input logic [REG_W-1:0] lim);
        logic [REG_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v >= $signed({{(SPAN_W-REG_W){1'b0}}, lim})) begin
            res = lim - 1'b1;
        end else begin
            res = v[REG_W-1:0];
        end
        return res;
    endfunction

    csrast_state_t state_reg, state_next;

    logic [REG_W-1:0]          width_reg, width_next;
    logic [REG_W-1:0]          height_reg, height_next;
    logic                      fill_mode_reg, fill_mode_next;
    logic                      active_reg, active_next;
    logic [ROW_W-1:0]          cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]          fin_row_reg, fin_row_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next;
    logic signed [COORD_W-1:0] cy_reg, cy_next;
    logic [RAD_W-1:0]          rad_reg, rad_next;
    logic [PIX_W-1:0]          color_reg, color_next;
    logic signed [EDGE_W-1:0]  top_reg, top_next;
    logic signed [EDGE_W-1:0]  bot_reg, bot_next;
    logic [REG_W-1:0]          hgt_reg, hgt_next;
    logic [RAD_W:0]            d_reg, d_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    csrast_out_t               out_reg, out_next;
    logic                      m_valid_reg, m_valid_next;

    logic                      accept;
    logic                      is_start;
    logic                      out_free;
    logic                      off_screen;
    logic                      top_neg;
    logic signed [EDGE_W-1:0]  hgt_s;
    logic [COORD_W-1:0]        cy_abs;
    logic [RAD_W-1:0]          abs_d;
    logic [RAD_W-1:0]          mul_a;
    logic [RAD_W:0]            mul_b;
    logic                      mul_start;
    logic                      mul_done;
    logic [REM_W-1:0]          mul_product;
    logic                      root_start;
    logic                      root_done;
    logic [RAD_W-1:0]          root;
    logic [REG_W-1:0]          wid_eff;
    logic signed [SPAN_W-1:0]  left_raw;
    logic signed [SPAN_W-1:0]  right_raw;
    logic                      last_row;
    logic                      emit;

    assign accept   = s_valid && s_ready;
    assign is_start = (s_data.opcode == OP_START);
    assign out_free = !m_valid_reg || m_ready;
    assign last_row = (cur_row_reg >= fin_row_reg);
    assign emit     = (state_reg == ST_EMIT) && out_free;

    always_comb begin
        hgt_s      = $signed({{(EDGE_W-REG_W){1'b0}}, hgt_reg});
        top_neg    = top_reg[EDGE_W-1];
        off_screen = bot_reg[EDGE_W-1] || (top_reg >= hgt_s);
        cy_abs     = cy_reg[COORD_W-1] ? (COORD_W'(0) - cy_reg) : cy_reg;
        abs_d      = top_neg ? cy_abs[RAD_W-1:0] : rad_reg;
        mul_a      = rad_reg - abs_d;
        mul_b      = {1'b0, rad_reg} + {1'b0, abs_d};
    end

    always_comb begin
        wid_eff   = eff_limit(width_reg, MAX_WIDTH);
        left_raw  = $signed({{2{cx_reg[COORD_W-1]}}, cx_reg})
                    - $signed({{(SPAN_W-RAD_W){1'b0}}, root});
        right_raw = $signed({{2{cx_reg[COORD_W-1]}}, cx_reg})
                    + $signed({{(SPAN_W-RAD_W){1'b0}}, root});
    end

    csrast_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    csrast_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .operand (rem_reg),
        .done    (root_done),
        .root    (root)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (is_start) begin
                        state_next = ST_PREP;
                    end else if (active_reg) begin
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_PREP: begin
                state_next = off_screen ? ST_IDLE : ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        mul_start  = 1'b0;
        root_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                root_start = s_valid && !is_start && active_reg;
            end
            ST_PREP: begin
                mul_start = !off_screen;
            end
            default: s_ready = 1'b0;
        endcase
    end

    always_comb begin
        width_next     = width_reg;
        height_next    = height_reg;
        fill_mode_next = fill_mode_reg;
        active_next    = active_reg;
        cur_row_next   = cur_row_reg;
        fin_row_next   = fin_row_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rad_next       = rad_reg;
        color_next     = color_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        hgt_next       = hgt_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        out_next       = out_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                REG_SCREEN_WIDTH:  width_next     = cfg_wdata;
                REG_SCREEN_HEIGHT: height_next    = cfg_wdata;
                REG_FILL_MODE:     fill_mode_next = cfg_wdata[0];
                default: ;
            endcase
        end

        if (accept && is_start) begin
            cx_next     = s_data.center_x;
            cy_next     = s_data.center_y;
            rad_next    = s_data.circle_radius;
            color_next  = ALPHA_OPAQUE | {{(PIX_W-COLOR_W){1'b0}}, s_data.fill_color};
            top_next    = $signed({s_data.center_y[COORD_W-1], s_data.center_y})
                          - $signed({{(EDGE_W-RAD_W){1'b0}}, s_data.circle_radius});
            bot_next    = $signed({s_data.center_y[COORD_W-1], s_data.center_y})
                          + $signed({{(EDGE_W-RAD_W){1'b0}}, s_data.circle_radius});
            hgt_next    = eff_limit(height_reg, MAX_HEIGHT);
            active_next = 1'b0;
        end

        if (state_reg == ST_PREP) begin
            active_next  = !off_screen;
            cur_row_next = top_neg ? '0 : top_reg[ROW_W-1:0];
            fin_row_next = (bot_reg >= hgt_s) ? (hgt_reg - 1'b1) : bot_reg[ROW_W-1:0];
            d_next       = top_neg ? ((RAD_W+1)'(0) - cy_reg[RAD_W:0])
                                   : ((RAD_W+1)'(0) - {1'b0, rad_reg});
        end

        if (state_reg == ST_MUL && mul_done) begin
            rem_next = mul_product;
        end

        if (emit) begin
            out_next.row         = cur_row_reg[OUT_W-1:0];
            out_next.span_start  = OUT_W'(clamp_col(left_raw, wid_eff));
            out_next.span_end    = OUT_W'(clamp_col(right_raw, wid_eff));
            out_next.pixel_color = color_reg;
            out_next.whole_span  = fill_mode_reg;
            out_next.last_span   = last_row;
            m_valid_next         = 1'b1;
            rem_next = rem_reg - {{(REM_W-RAD_W-2){d_reg[RAD_W]}}, d_reg, 1'b1};
            d_next   = d_reg + 1'b1;
            if (last_row) begin
                active_next = 1'b0;
            end else begin
                cur_row_next = cur_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            width_reg     <= RST_SCREEN_WIDTH;
            height_reg    <= RST_SCREEN_HEIGHT;
            fill_mode_reg <= RST_FILL_MODE;
            active_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            fill_mode_reg <= fill_mode_next;
            active_reg    <= active_next;
            m_valid_reg   <= m_valid_next;
        end
        cur_row_reg <= cur_row_next;
        fin_row_reg <= fin_row_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        rad_reg     <= rad_next;
        color_reg   <= color_next;
        top_reg     <= top_next;
        bot_reg     <= bot_next;
        hgt_reg     <= hgt_next;
        d_reg       <= d_next;
        rem_reg     <= rem_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_mul_done_in_mul : assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the multiply state");

    a_root_done_in_root : assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> (state_reg == ST_ROOT))
        else $error("square root finished outside the root state");

    a_span_ordered : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data.span_start <= m_data.span_end) || (MAX_WIDTH > 4096)))
        else $error("span start lies beyond span end");

    a_alpha_opaque : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data.pixel_color[PIX_W-1 -: 8] == 8'hff))
        else $error("result colour is not opaque");
`endif

endmodule
